FILE: rtl/rqr_pkg.sv
// Shared constants, codes and controller/datapath types for the ring queue.
package rqr_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REV  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                start;
    logic [STATUS_W-1:0] status;
    logic                push;
    logic                pop;
    logic                rev_start;
    logic                pop_cap;
    logic                rev_rlo;
    logic                rev_rhi;
    logic                rev_wlo;
    logic                rev_whi;
    logic                finish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last_item;
    logic few;
    logic last_pair;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/rqr_if.sv
// Request and result channel interfaces of the ring queue.
interface rqr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [rqr_pkg::CMD_W-1:0]     command;
  logic signed [rqr_pkg::VALUE_W-1:0]   push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink (input valid, command, push_value, output ready);
endinterface

interface rqr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rqr_pkg::VALUE_W-1:0]   front_value;
  logic signed [rqr_pkg::VALUE_W-1:0]   rear_value;
  logic        [rqr_pkg::COUNT_W-1:0]   item_count;
  logic        [rqr_pkg::STATUS_W-1:0]  status;

  modport source (output valid, front_value, rear_value, item_count, status, input ready);
  modport sink (input valid, front_value, rear_value, item_count, status, output ready);
endinterface

FILE: rtl/rqr_ram.sv
// Generic single write, single read RAM with registered read data.
module rqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rqr_ctrl.sv
// Command sequencer of the ring queue.
module rqr_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rqr_pkg::CMD_W-1:0]    command,
  input  rqr_pkg::dp_stat_t            stat,
  output rqr_pkg::dp_cmd_t             cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_RLO  = 3'd2;
  localparam logic [2:0] S_RHI  = 3'd3;
  localparam logic [2:0] S_WLO  = 3'd4;
  localparam logic [2:0] S_WHI  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE) && stat.out_free;
    unique case (state_r)
      S_IDLE: begin
        if (in_ready && in_valid) begin
          cmd.start  = 1'b1;
          cmd.status = rqr_pkg::ST_DONE;
          state_nxt  = S_FIN;
          unique case (command)
            rqr_pkg::CMD_PUSH: begin
              if (stat.full) begin
                cmd.status = rqr_pkg::ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            rqr_pkg::CMD_POP: begin
              if (stat.empty) begin
                cmd.status = rqr_pkg::ST_EMPTY;
              end else begin
                cmd.pop = 1'b1;
                // The new front has to be fetched unless the queue drains.
                if (!stat.last_item) begin
                  state_nxt = S_POP;
                end
              end
            end
            rqr_pkg::CMD_REV: begin
              if (!stat.few) begin
                cmd.rev_start = 1'b1;
                state_nxt     = S_RLO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop_cap = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RLO: begin
        cmd.rev_rlo = 1'b1;
        state_nxt   = S_RHI;
      end
      S_RHI: begin
        cmd.rev_rhi = 1'b1;
        state_nxt   = S_WLO;
      end
      S_WLO: begin
        cmd.rev_wlo = 1'b1;
        state_nxt   = S_WHI;
      end
      S_WHI: begin
        cmd.rev_whi = 1'b1;
        state_nxt   = stat.last_pair ? S_FIN : S_RLO;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/rqr_dp.sv
// Pointers, count, cached end values, item store and result register of the ring queue.
module rqr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rqr_pkg::dp_cmd_t                     cmd,
  output rqr_pkg::dp_stat_t                    stat,
  input  logic signed [rqr_pkg::VALUE_W-1:0]   push_value,
  input  logic                                 cfg_we,
  input  logic        [rqr_pkg::CAP_W-1:0]     cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rqr_pkg::VALUE_W-1:0]   front_value,
  output logic signed [rqr_pkg::VALUE_W-1:0]   rear_value,
  output logic        [rqr_pkg::COUNT_W-1:0]   item_count,
  output logic        [rqr_pkg::STATUS_W-1:0]  status
);

  localparam int unsigned AW = rqr_pkg::ADDR_W;
  localparam int unsigned CW = rqr_pkg::CNT_W;
  localparam int unsigned DW = rqr_pkg::DATA_WIDTH;
  localparam logic [AW-1:0] LAST_SLOT = AW'(rqr_pkg::DEPTH - 1);

  logic [AW-1:0] head_r, tail_r, lo_r, hi_r;
  logic [CW-1:0] count_r, pairs_r;
  logic [rqr_pkg::CAP_W-1:0] cap_r;
  logic [DW-1:0] front_r, rear_r, tmp_r;
  logic [rqr_pkg::STATUS_W-1:0] status_r;

  logic                            out_valid_r;
  logic [rqr_pkg::VALUE_W-1:0]     out_front_r, out_rear_r;
  logic [rqr_pkg::COUNT_W-1:0]     out_count_r;
  logic [rqr_pkg::STATUS_W-1:0]    out_status_r;

  logic [AW-1:0] head_inc, tail_inc, tail_dec, lo_inc, hi_dec;
  logic [CW-1:0] limit;
  logic [DW-1:0] word;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_SLOT : tail_r - 1'b1;
  assign lo_inc   = (lo_r == LAST_SLOT) ? '0 : lo_r + 1'b1;
  assign hi_dec   = (hi_r == '0) ? LAST_SLOT : hi_r - 1'b1;

  // A limit above the store depth is clipped to the depth.
  assign limit = (32'(cap_r) > rqr_pkg::DEPTH) ? CW'(rqr_pkg::DEPTH) : CW'(cap_r);
  assign word  = DW'(push_value);

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r >= limit);
  assign stat.last_item = (count_r == CW'(1));
  assign stat.few       = (count_r < CW'(2));
  assign stat.last_pair = (pairs_r == CW'(1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = word;
    ram_raddr = head_inc;
    if (cmd.push) begin
      ram_we = 1'b1;
    end else if (cmd.rev_wlo) begin
      ram_we    = 1'b1;
      ram_waddr = lo_r;
      ram_wdata = ram_rdata;
    end else if (cmd.rev_whi) begin
      ram_we    = 1'b1;
      ram_waddr = hi_r;
      ram_wdata = tmp_r;
    end
    if (cmd.rev_rlo) begin
      ram_raddr = lo_r;
    end else if (cmd.rev_rhi) begin
      ram_raddr = hi_r;
    end
  end

  rqr_ram #(
    .WIDTH (DW),
    .DEPTH (rqr_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cap_r       <= rqr_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.push) begin
        tail_r  <= tail_inc;
        count_r <= count_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      status_r <= cmd.status;
    end
    if (cmd.push) begin
      rear_r <= word;
      if (count_r == '0) begin
        front_r <= word;
      end
    end
    if (cmd.pop_cap) begin
      front_r <= ram_rdata;
    end
    // After a reverse the old rear is the front, so the cached ends trade places.
    if (cmd.rev_start) begin
      front_r <= rear_r;
      rear_r  <= front_r;
      lo_r    <= head_r;
      hi_r    <= tail_dec;
      pairs_r <= count_r >> 1;
    end
    if (cmd.rev_rhi) begin
      tmp_r <= ram_rdata;
    end
    if (cmd.rev_whi) begin
      lo_r    <= lo_inc;
      hi_r    <= hi_dec;
      pairs_r <= pairs_r - 1'b1;
    end
    if (cmd.finish) begin
      out_front_r  <= (count_r == '0) ? '0 : rqr_pkg::VALUE_W'(front_r);
      out_rear_r   <= (count_r == '0) ? '0 : rqr_pkg::VALUE_W'(rear_r);
      out_count_r  <= rqr_pkg::COUNT_W'(count_r);
      out_status_r <= status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign front_value = out_front_r;
  assign rear_value  = out_rear_r;
  assign item_count  = out_count_r;
  assign status      = out_status_r;

endmodule

FILE: rtl/ring_queue_with_reverse.sv
// Top level of the ring queue with push, pop, reverse and peek.
//
//   channel   direction  contents
//   in_ch     sink       command, push_value
//   out_ch    source     front_value, rear_value, item_count, status
//   cfg_*     write      capacity_limit (cfg_we, cfg_wdata)
//
// Push, peek, refused requests and a pop that empties the queue pass from idle
// straight to the finish state; any other pop first passes a state that captures
// the new front from the store's read port. Reverse swaps each pair with two reads
// and two writes, issued one store access per cycle.
// Reset is synchronous and active low and empties the queue; the limit returns to 16.
// A request is taken while idle, with the result register empty or being drained.
module ring_queue_with_reverse (
  input  logic                         clk,
  input  logic                         rst_n,
  rqr_in_if.sink                       in_ch,
  rqr_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [rqr_pkg::CAP_W-1:0]    cfg_wdata
);

  rqr_pkg::dp_cmd_t  cmd;
  rqr_pkg::dp_stat_t stat;

  rqr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .command  (in_ch.command),
    .stat     (stat),
    .cmd      (cmd)
  );

  rqr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .push_value  (in_ch.push_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .front_value (out_ch.front_value),
    .rear_value  (out_ch.rear_value),
    .item_count  (out_ch.item_count),
    .status      (out_ch.status)
  );

endmodule
